@@ hw/rtl/csfw_pkg.sv @@
// Shared types, sizes and codes for the counting semaphore with FIFO waiters.
// No dependencies; every other file in hw/rtl imports this package.
package csfw_pkg;

  // wait queue sizing
  localparam int MAX_WAITERS = 16;
  localparam int PTR_W       = $clog2(MAX_WAITERS);
  localparam int CNT_W       = $clog2(MAX_WAITERS + 1);

  // field widths
  localparam int TID_W    = 8;
  localparam int SEM_W    = 8;
  localparam int STATUS_W = 3;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;
  localparam int REG_IDX_W = 1;

  localparam logic [SEM_W-1:0] SEM_MAX = '1;

  // operation codes
  localparam logic CMD_TAKE = 1'b0;
  localparam logic CMD_GIVE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_GRANTED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BLOCKED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RAISED    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_WOKEN     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_SATURATED = 3'd5;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_INITIAL_COUNT = 1'b0;

  typedef struct packed {
    logic             cmd;
    logic [TID_W-1:0] thread_id;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TID_W-1:0]    woken_thread;
    logic [SEM_W-1:0]    count_now;
    logic [CNT_W-1:0]    waiters_now;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic exec;
    logic load;
  } dp_cmd_t;

endpackage

@@ hw/rtl/csfw_ctrl.sv @@
// Controller: request handshake state machine and configuration write decode.
// Depends on csfw_pkg.
module csfw_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  output logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [csfw_pkg::ADDR_W-1:0]   paddr,
  output csfw_pkg::dp_cmd_t             cmd
);
  import csfw_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic                 state;
  logic                 state_next;
  logic                 in_accept;
  logic                 out_accept;
  logic [REG_IDX_W-1:0] reg_idx;

  // a new request may enter while the held result is being taken
  assign out_valid  = (state == S_HOLD);
  assign in_stall   = out_valid && out_stall;
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;
  assign reg_idx    = paddr[ADDR_W-1 -: REG_IDX_W];

  // datapath commands
  always_comb begin
    cmd.exec = in_accept;
    cmd.load = 1'b0;
    if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_INITIAL_COUNT: cmd.load = 1'b1;
        default:           cmd.load = 1'b0;
      endcase
    end
  end

  // state transitions
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept) state_next = S_HOLD;
      end
      S_HOLD: begin
        if (!in_accept && out_accept) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted request produced no result");

  a_taken_drains: assert property (@(posedge clk) disable iff (rst)
    (out_accept && !in_accept) |=> !out_valid)
    else $error("result repeated after being taken");

endmodule

@@ hw/rtl/csfw_dp.sv @@
// Datapath: semaphore count, wait queue storage and pointers, result register.
// Depends on csfw_pkg.
module csfw_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  csfw_pkg::dp_cmd_t           cmd,
  input  csfw_pkg::req_t              req,
  input  logic [csfw_pkg::SEM_W-1:0]  load_value,
  output logic [csfw_pkg::SEM_W-1:0]  initial_count,
  output csfw_pkg::rsp_t              rsp
);
  import csfw_pkg::*;

  logic [SEM_W-1:0] sem_count;
  logic [SEM_W-1:0] sem_count_next;
  logic [PTR_W-1:0] queue_head;
  logic [PTR_W-1:0] queue_head_next;
  logic [PTR_W-1:0] queue_tail;
  logic [PTR_W-1:0] queue_tail_next;
  logic [CNT_W-1:0] waiter_count;
  logic [CNT_W-1:0] waiter_count_next;
  logic [TID_W-1:0] wait_queue [MAX_WAITERS];
  logic             push;
  rsp_t             rsp_next;

  // operation decode and next state
  always_comb begin
    sem_count_next    = sem_count;
    queue_head_next   = queue_head;
    queue_tail_next   = queue_tail;
    waiter_count_next = waiter_count;
    push              = 1'b0;
    rsp_next.status       = ST_GRANTED;
    rsp_next.woken_thread = '0;
    if (cmd.load) begin
      sem_count_next    = load_value;
      queue_head_next   = '0;
      queue_tail_next   = '0;
      waiter_count_next = '0;
    end else if (cmd.exec) begin
      case (req.cmd)
        CMD_TAKE: begin
          if (sem_count != '0) begin
            sem_count_next  = sem_count - 1'b1;
            rsp_next.status = ST_GRANTED;
          end else if (waiter_count == CNT_W'(MAX_WAITERS)) begin
            rsp_next.status = ST_FULL;
          end else begin
            push              = 1'b1;
            queue_tail_next   = (queue_tail == PTR_W'(MAX_WAITERS - 1)) ? '0
                                                                        : queue_tail + 1'b1;
            waiter_count_next = waiter_count + 1'b1;
            rsp_next.status   = ST_BLOCKED;
          end
        end
        default: begin
          if (waiter_count != '0) begin
            rsp_next.woken_thread = wait_queue[queue_head];
            queue_head_next   = (queue_head == PTR_W'(MAX_WAITERS - 1)) ? '0
                                                                        : queue_head + 1'b1;
            waiter_count_next = waiter_count - 1'b1;
            rsp_next.status   = ST_WOKEN;
          end else if (sem_count == SEM_MAX) begin
            rsp_next.status = ST_SATURATED;
          end else begin
            sem_count_next  = sem_count + 1'b1;
            rsp_next.status = ST_RAISED;
          end
        end
      endcase
    end
    rsp_next.count_now   = sem_count_next;
    rsp_next.waiters_now = waiter_count_next;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      sem_count     <= '0;
      queue_head    <= '0;
      queue_tail    <= '0;
      waiter_count  <= '0;
      initial_count <= '0;
    end else begin
      sem_count    <= sem_count_next;
      queue_head   <= queue_head_next;
      queue_tail   <= queue_tail_next;
      waiter_count <= waiter_count_next;
      if (cmd.load) initial_count <= load_value;
    end
  end

  // queue storage and result register
  always_ff @(posedge clk) begin
    if (push) wait_queue[queue_tail] <= req.thread_id;
    if (cmd.exec && !cmd.load) rsp <= rsp_next;
  end

  a_waiters_bounded: assert property (@(posedge clk) disable iff (rst)
    waiter_count <= CNT_W'(MAX_WAITERS))
    else $error("waiter count beyond queue depth");

  a_waiters_need_zero_count: assert property (@(posedge clk) disable iff (rst)
    (waiter_count != '0) |-> (sem_count == '0))
    else $error("threads waiting while count is nonzero");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && !cmd.load) |=>
      (rsp.count_now == sem_count) && (rsp.waiters_now == waiter_count))
    else $error("result does not reflect updated state");

endmodule

@@ hw/rtl/counting_semaphore_fifo_waiters.sv @@
// Counting semaphore with a FIFO of blocked thread ids. Each request (take or
// give) is executed in the cycle it is accepted and its result is registered,
// so the result is offered on the following cycle. A new request is accepted
// whenever the output register is empty or being taken in the same cycle, so
// one request per cycle is sustained while out_stall stays low; a held result
// stalls the input. The wait queue holds up to 16 thread ids in flip-flops.
// Writing register 0 (initial_count) reloads the count and empties the queue.
// Depends on csfw_pkg, csfw_ctrl and csfw_dp.
module counting_semaphore_fifo_waiters (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  csfw_pkg::req_t                 in_req,
  output logic                           out_valid,
  input  logic                           out_stall,
  output csfw_pkg::rsp_t                 out_rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [csfw_pkg::ADDR_W-1:0]    paddr,
  input  logic [csfw_pkg::DATA_W-1:0]    pwdata,
  output logic [csfw_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);
  import csfw_pkg::*;

  dp_cmd_t          cmd;
  logic [SEM_W-1:0] initial_count;

  assign pready = 1'b1;

  // register read decode
  always_comb begin
    unique case (paddr[ADDR_W-1 -: REG_IDX_W])
      REG_INITIAL_COUNT: prdata = DATA_W'(initial_count);
      default:           prdata = '0;
    endcase
  end

  csfw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .cmd       (cmd)
  );

  csfw_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .req           (in_req),
    .load_value    (pwdata[SEM_W-1:0]),
    .initial_count (initial_count),
    .rsp           (out_rsp)
  );

endmodule
